>>> rtl/wam_pkg.sv
// Shared types, constants and helper functions of the weighted adjacency matrix.
`timescale 1ns / 1ps
package wam_pkg;

  localparam int NUM_VERTICES = 6;
  localparam int WEIGHT_BITS  = 16;
  localparam int NUM_ENTRIES  = NUM_VERTICES * NUM_VERTICES;
  localparam int VTX_W        = $clog2(NUM_VERTICES);
  localparam int ADDR_W       = $clog2(NUM_ENTRIES);
  localparam int FIELD_VTX_W  = 4;
  localparam int FIELD_WT_W   = 16;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [VTX_W-1:0]       vidx_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [FIELD_VTX_W-1:0] vfield_t;
  typedef logic [FIELD_WT_W-1:0]  wfield_t;

  localparam vidx_t LAST_IDX = VTX_W'(NUM_VERTICES - 1);

  typedef enum logic {
    OP_QUERY  = 1'b0,
    OP_MODIFY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FLUSH,
    ST_CHECK,
    ST_MIRROR,
    ST_ERROR
  } state_t;

  typedef struct packed {
    op_t     operation;
    vfield_t vertex_a;
    vfield_t vertex_b;
    wfield_t edge_weight;
  } in_item_t;

  typedef struct packed {
    kind_t   kind;
    vfield_t neighbour;
    wfield_t neighbour_weight;
    logic    last;
  } out_item_t;

  function automatic logic vertex_ok(vfield_t v);
    return (v != '0) && (int'(v) <= NUM_VERTICES);
  endfunction

  function automatic vidx_t to_vidx(vfield_t v);
    vfield_t d;
    d = v - vfield_t'(1);
    return VTX_W'(d);
  endfunction

  function automatic addr_t entry_addr(vidx_t row, vidx_t col);
    return ADDR_W'(int'(row) * NUM_VERTICES + int'(col));
  endfunction

  function automatic out_item_t make_result(kind_t k, vfield_t nb, weight_t wt, logic lst);
    out_item_t r;
    r.kind             = k;
    r.neighbour        = nb;
    r.neighbour_weight = FIELD_WT_W'(wt);
    r.last             = lst;
    return r;
  endfunction

endpackage

>>> rtl/wam_in_if.sv
// Input channel interface carrying query and modify transactions.
`timescale 1ns / 1ps
interface wam_in_if;
  logic               valid;
  logic               ready;
  wam_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wam_out_if.sv
// Result channel interface carrying neighbor, empty and error transactions.
`timescale 1ns / 1ps
interface wam_out_if;
  logic               valid;
  logic               ready;
  wam_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wam_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module wam_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/weighted_adjacency_matrix_core.sv
// Top level of the weighted adjacency matrix: sequencer, matrix store and result register.
//
//   channel  | role   | transaction
//   ---------+--------+--------------------------------------------------------
//   in_ch    | sink   | query of one vertex, or modify of the edge between two
//   out_ch   | source | neighbor entry, empty marker or error, last on final one
//
// A query walks one matrix row entry per cycle, unless the result register stalls,
// through the single RAM read port, then flushes the last entry; a modify does a check
// read, then the two mirrored writes through the single write port.
// An error is raised after decode, or after the check when deleting a missing edge, then handed off.
// Reset clears the per-entry valid bits, so the matrix reads as empty.
// A stalled result register holds the scan; nothing new is taken until idle.
`timescale 1ns / 1ps
module weighted_adjacency_matrix_core (
  input  logic             clk,
  input  logic             rst_n,
  wam_in_if.sink           in_ch,
  wam_out_if.source        out_ch
);

  wam_pkg::state_t    state_r, state_nxt;
  wam_pkg::op_t       op_r;
  wam_pkg::vfield_t   va_r, vb_r;
  wam_pkg::weight_t   wt_r;
  wam_pkg::addr_t     base_r;
  wam_pkg::vidx_t     idx_r;
  logic               pend_vld_r;
  wam_pkg::vfield_t   pend_nb_r;
  wam_pkg::weight_t   pend_wt_r;
  logic               out_vld_r;
  wam_pkg::out_item_t out_data_r;
  logic [wam_pkg::NUM_ENTRIES-1:0] valid_r;
  logic               rvld_r;

  logic               in_ready;
  logic               ram_we;
  wam_pkg::addr_t     ram_waddr;
  wam_pkg::addr_t     ram_raddr;
  wam_pkg::weight_t   ram_rdata;
  logic               out_load;
  wam_pkg::out_item_t out_nxt;
  logic               step;
  logic               out_free;
  wam_pkg::weight_t   entry_wt;
  logic               entry_nz;
  wam_pkg::vidx_t     ia, ib;
  logic               ok_a, ok_b;
  logic               del_missing;

  wam_ram #(
    .DATA_W (wam_pkg::WEIGHT_BITS),
    .DEPTH  (wam_pkg::NUM_ENTRIES)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wt_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ia          = wam_pkg::to_vidx(va_r);
  assign ib          = wam_pkg::to_vidx(vb_r);
  assign ok_a        = wam_pkg::vertex_ok(va_r);
  assign ok_b        = wam_pkg::vertex_ok(vb_r);
  assign entry_wt    = rvld_r ? ram_rdata : '0;
  assign entry_nz    = (entry_wt != '0);
  assign out_free    = !out_vld_r || out_ch.ready;
  assign del_missing = (wt_r == '0) && !entry_nz;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wam_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = wam_pkg::ST_DECODE;
        end
      end
      wam_pkg::ST_DECODE: begin
        if (op_r == wam_pkg::OP_QUERY) begin
          state_nxt = ok_a ? wam_pkg::ST_SCAN : wam_pkg::ST_ERROR;
        end else begin
          state_nxt = (ok_a && ok_b) ? wam_pkg::ST_CHECK : wam_pkg::ST_ERROR;
        end
      end
      wam_pkg::ST_SCAN: begin
        if (step && idx_r == wam_pkg::LAST_IDX) begin
          state_nxt = wam_pkg::ST_FLUSH;
        end
      end
      wam_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_nxt = wam_pkg::ST_IDLE;
        end
      end
      wam_pkg::ST_CHECK: begin
        state_nxt = del_missing ? wam_pkg::ST_ERROR : wam_pkg::ST_MIRROR;
      end
      wam_pkg::ST_MIRROR: begin
        state_nxt = wam_pkg::ST_IDLE;
      end
      wam_pkg::ST_ERROR: begin
        if (out_free) begin
          state_nxt = wam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wam_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wam_pkg::entry_addr(ia, ib);
    ram_raddr = base_r + wam_pkg::ADDR_W'(idx_r);
    out_load  = 1'b0;
    out_nxt   = wam_pkg::make_result(wam_pkg::KIND_ERROR, '0, '0, 1'b1);
    step      = 1'b0;
    unique case (state_r)
      wam_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      wam_pkg::ST_DECODE: begin
        if (op_r == wam_pkg::OP_QUERY) begin
          ram_raddr = wam_pkg::entry_addr(ia, '0);
        end else begin
          ram_raddr = wam_pkg::entry_addr(ia, ib);
        end
      end
      wam_pkg::ST_SCAN: begin
        step = !(entry_nz && pend_vld_r && !out_free);
        if (step && idx_r != wam_pkg::LAST_IDX) begin
          ram_raddr = base_r + wam_pkg::ADDR_W'(idx_r + wam_pkg::VTX_W'(1));
        end
        if (step && entry_nz && pend_vld_r) begin
          out_load = 1'b1;
          out_nxt  = wam_pkg::make_result(wam_pkg::KIND_ENTRY, pend_nb_r, pend_wt_r, 1'b0);
        end
      end
      wam_pkg::ST_FLUSH: begin
        out_load = out_free;
        if (pend_vld_r) begin
          out_nxt = wam_pkg::make_result(wam_pkg::KIND_ENTRY, pend_nb_r, pend_wt_r, 1'b1);
        end else begin
          out_nxt = wam_pkg::make_result(wam_pkg::KIND_EMPTY, '0, '0, 1'b1);
        end
      end
      wam_pkg::ST_CHECK: begin
        ram_we = !del_missing;
      end
      wam_pkg::ST_MIRROR: begin
        ram_we    = 1'b1;
        ram_waddr = wam_pkg::entry_addr(ib, ia);
      end
      wam_pkg::ST_ERROR: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wam_pkg::ST_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      valid_r    <= '0;
      rvld_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rvld_r  <= valid_r[ram_raddr];
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (state_r == wam_pkg::ST_DECODE) begin
        pend_vld_r <= 1'b0;
      end else if (state_r == wam_pkg::ST_SCAN && step && entry_nz) begin
        pend_vld_r <= 1'b1;
      end else if (state_r == wam_pkg::ST_FLUSH && out_free) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      op_r <= in_ch.data.operation;
      va_r <= in_ch.data.vertex_a;
      vb_r <= in_ch.data.vertex_b;
      wt_r <= wam_pkg::WEIGHT_BITS'(in_ch.data.edge_weight);
    end
    if (state_r == wam_pkg::ST_DECODE) begin
      base_r <= wam_pkg::entry_addr(ia, '0);
      idx_r  <= '0;
    end else if (state_r == wam_pkg::ST_SCAN && step) begin
      if (entry_nz) begin
        pend_nb_r <= wam_pkg::FIELD_VTX_W'(idx_r) + wam_pkg::vfield_t'(1);
        pend_wt_r <= entry_wt;
      end
      if (idx_r != wam_pkg::LAST_IDX) begin
        idx_r <= idx_r + wam_pkg::VTX_W'(1);
      end
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  a_mirror_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wam_pkg::ST_MIRROR) |-> $past(ram_we))
    else $error("Mirrored write without a preceding checked write.");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("Result register loaded while a result is still waiting.");

  a_pending_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wam_pkg::ST_SCAN && !step) |=> ($stable(pend_nb_r) && $stable(idx_r)))
    else $error("Pending neighbor changed during a stalled scan.");

endmodule
